@@ design/voxel_dilate_3x3x3_assert.svh @@
// assertion macros for the voxel dilation block
`ifndef VOXEL_DILATE_3X3X3_ASSERT_SVH
`define VOXEL_DILATE_3X3X3_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define VD3_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vd3 assertion failed");

// next-cycle implication
`define VD3_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vd3 assertion failed");

`else

`define VD3_ASSERT_IMP(label, clk, rst, ante, cons)
`define VD3_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ design/vd3_pkg.sv @@
`timescale 1ns / 1ps

package vd3_pkg;

  // default volume limits
  localparam int DEF_MAX_X = 256;
  localparam int DEF_MAX_Y = 256;
  localparam int DEF_MAX_Z = 256;

  // configuration port
  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int SIZE_RESET = 256;

  // stream data width in bits
  localparam int TDATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_reg_t;

  // per-word control carried from the address stage to the combine stage
  typedef struct packed {
    logic s_valid;  // row store update due
    logic r_valid;  // plane store update due
    logic emit;     // word produces a result
    logic fin;      // result is the last voxel of the volume
    logic y_lo;     // row above exists
    logic y_hi;     // row below exists
    logic z_lo;     // plane before exists
    logic z_hi;     // plane after exists
    logic ox;       // or over x for this column
  } vd3_ctrl_t;

endpackage

@@ design/voxel_dilate_3x3x3.sv @@
`timescale 1ns / 1ps
// a result goes via the stage 1 and output registers after the word that completes it
// is taken; the result for voxel p rides on stream word p + 1 + size_x + size_x*size_y
// throughput: one word per cycle while no result is held, set by the single read-modify-write of each store
// reset: clears sizes to 256 (clamped to the limits), positions, x window and handshake
// state; row and plane stores are not cleared and need no clearing pass
module voxel_dilate_3x3x3 #(
  parameter int MAX_X = vd3_pkg::DEF_MAX_X,
  parameter int MAX_Y = vd3_pkg::DEF_MAX_Y,
  parameter int MAX_Z = vd3_pkg::DEF_MAX_Z
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [vd3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vd3_pkg::CFG_W-1:0]     cfg_data,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [vd3_pkg::TDATA_W-1:0]   s_axis_tdata,  // [0] occupied
  input  logic                          s_axis_tuser,  // [0] mode
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [vd3_pkg::TDATA_W-1:0]   m_axis_tdata,  // [0] dilated
  output logic                          m_axis_tlast
);

  import vd3_pkg::*;

  localparam int XW  = $clog2(MAX_X + 1);
  localparam int YW  = $clog2(MAX_Y + 1);
  localparam int ZSW = $clog2(MAX_Z + 1);
  localparam int XIW = $clog2(MAX_X);
  localparam int YIW = $clog2(MAX_Y);
  localparam int ZW  = $clog2(MAX_Z + 3);
  localparam int PD  = MAX_X * MAX_Y;
  localparam int PW  = $clog2(PD);

  function automatic int clamp_size(input logic [CFG_W-1:0] v, input int maxv);
    int r;
    r = int'(v);
    if (r == 0) begin
      r = 1;
    end else if (r > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

  // volume size registers
  logic [XW-1:0]  size_x;
  logic [YW-1:0]  size_y;
  logic [ZSW-1:0] size_z;
  logic           restart;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= XW'(clamp_size(CFG_W'(SIZE_RESET), MAX_X));
      size_y <= YW'(clamp_size(CFG_W'(SIZE_RESET), MAX_Y));
      size_z <= ZSW'(clamp_size(CFG_W'(SIZE_RESET), MAX_Z));
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_X: size_x <= XW'(clamp_size(cfg_data, MAX_X));
        REG_SIZE_Y: size_y <= YW'(clamp_size(cfg_data, MAX_Y));
        REG_SIZE_Z: size_z <= ZSW'(clamp_size(cfg_data, MAX_Z));
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z: restart = cfg_we;
      default:                            restart = 1'b0;
    endcase
  end

  // position state
  logic           started;   // at least one word taken this volume
  logic [XIW-1:0] qx;        // coordinates of the incoming word
  logic [YIW-1:0] qy;
  logic [ZW-1:0]  qz;
  logic [XIW-1:0] s_x;       // column of the previous word
  logic           s_rownz;   // previous word is past the first row
  logic [YIW-1:0] ry;        // row and plane of the word one row back
  logic [ZW-1:0]  rz;
  logic [PW-1:0]  pa;        // plane store address of that word
  logic [1:0]     x_window;

  // stage 1 and output
  logic           s1_valid;
  vd3_ctrl_t      s1_ctrl;
  logic [XIW-1:0] s1_xa;
  logic [PW-1:0]  s1_pa;
  logic [1:0]     re_data;
  logic [1:0]     pe_data;
  logic           s1_adv;
  logic           out_free;

  // address stage
  logic      in_fire;
  logic      beyond;
  logic      step;
  logic      a_bit;
  logic      q_xlast;
  logic      q_ylast;
  logic      s_xlast;
  logic      r_ylast;
  vd3_ctrl_t ctrl0;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign beyond  = qz >= ZW'(size_z);
  assign step    = in_fire && (beyond || !s_axis_tuser);
  assign a_bit   = !beyond && s_axis_tdata[0];
  assign q_xlast = XW'(qx) == size_x - XW'(1);
  assign q_ylast = YW'(qy) == size_y - YW'(1);
  assign s_xlast = XW'(s_x) == size_x - XW'(1);
  assign r_ylast = YW'(ry) == size_y - YW'(1);

  // window flags for the word being taken
  always_comb begin
    ctrl0.s_valid = started;
    ctrl0.r_valid = started && s_rownz;
    ctrl0.emit    = ctrl0.r_valid && (rz != '0);
    ctrl0.fin     = ctrl0.emit && (rz == ZW'(size_z)) && s_xlast && r_ylast;
    ctrl0.y_lo    = ry != '0;
    ctrl0.y_hi    = !r_ylast;
    ctrl0.z_lo    = rz >= ZW'(2);
    ctrl0.z_hi    = rz < ZW'(size_z);
    ctrl0.ox      = x_window[0] || ((s_x != '0) && x_window[1]) || (!s_xlast && a_bit);
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst || restart || (step && ctrl0.fin)) begin
      started  <= 1'b0;
      qx       <= '0;
      qy       <= '0;
      qz       <= '0;
      s_x      <= '0;
      s_rownz  <= 1'b0;
      ry       <= '0;
      rz       <= '0;
      pa       <= '0;
      x_window <= '0;
    end else if (step) begin
      started  <= 1'b1;
      s_x      <= qx;
      s_rownz  <= (qy != '0) || (qz != '0);
      x_window <= {x_window[0], a_bit};
      if (q_xlast) begin
        qx <= '0;
        if (q_ylast) begin
          qy <= '0;
          qz <= qz + 1'b1;
        end else begin
          qy <= qy + 1'b1;
        end
      end else begin
        qx <= qx + 1'b1;
      end
      if (ctrl0.r_valid) begin
        if (s_xlast && r_ylast) begin
          pa <= '0;
        end else begin
          pa <= pa + 1'b1;
        end
        if (s_xlast) begin
          if (r_ylast) begin
            ry <= '0;
            rz <= rz + 1'b1;
          end else begin
            ry <= ry + 1'b1;
          end
        end
      end
    end
  end

  // stores
  logic       oy;
  logic       res;

  vd3_ram #(
    .DEPTH (MAX_X),
    .WIDTH (2)
  ) u_row_store (
    .clk   (clk),
    .we    (s1_adv && s1_ctrl.s_valid),
    .waddr (s1_xa),
    .wdata ({re_data[0], s1_ctrl.ox}),
    .re    (step),
    .raddr (s_x),
    .rdata (re_data)
  );

  vd3_ram #(
    .DEPTH (PD),
    .WIDTH (2)
  ) u_plane_store (
    .clk   (clk),
    .we    (s1_adv && s1_ctrl.r_valid),
    .waddr (s1_pa),
    .wdata ({pe_data[0], oy}),
    .re    (step),
    .raddr (pa),
    .rdata (pe_data)
  );

  // stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= step;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_ctrl <= ctrl0;
      s1_xa   <= s_x;
      s1_pa   <= pa;
    end
  end

  // or over y and z
  assign oy  = re_data[0] || (s1_ctrl.y_lo && re_data[1]) || (s1_ctrl.y_hi && s1_ctrl.ox);
  assign res = pe_data[0] || (s1_ctrl.z_lo && pe_data[1]) || (s1_ctrl.z_hi && oy);

  // handshake between stages
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_adv        = s1_valid && (!s1_ctrl.emit || out_free);
  assign s_axis_tready = !s1_valid || s1_adv;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv && s1_ctrl.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctrl.emit) begin
      m_axis_tdata <= {{(TDATA_W-1){1'b0}}, res};
      m_axis_tlast <= s1_ctrl.fin;
    end
  end

`include "voxel_dilate_3x3x3_assert.svh"

  // input side only stalls behind a held result
  `VD3_ASSERT_IMP(a_stall_cause, clk, rst, !s_axis_tready, s1_valid && m_axis_tvalid && !m_axis_tready)
  // last voxel of the volume restarts the positions
  `VD3_ASSERT_NEXT(a_final_restart, clk, rst, step && ctrl0.fin, !started && qx == '0 && rz == '0)
  // a result leaving stage 1 lands in the output register
  `VD3_ASSERT_NEXT(a_emit_out, clk, rst, s1_adv && s1_ctrl.emit, m_axis_tvalid && (m_axis_tlast == $past(s1_ctrl.fin)))
  // the trailing plane never passes the volume
  `VD3_ASSERT_IMP(a_rz_bound, clk, rst, started, rz <= ZW'(size_z))

endmodule

@@ design/vd3_ram.sv @@
`timescale 1ns / 1ps

module vd3_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, new data returned on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule
